FILE: rtl/tts_pkg.sv
package tts_pkg;

    // Width of the token length counter; lengths saturate at all ones.
    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    localparam int KIND_W = 5;

    // Token kinds as they appear on the result channel.
    localparam logic [KIND_W-1:0] KIND_SPACE     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NEWLINE   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_INTEGER   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_STRING    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_SLASH     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_DASH      = 5'd6;
    localparam logic [KIND_W-1:0] KIND_EQUAL     = 5'd7;
    localparam logic [KIND_W-1:0] KIND_SEMICOLON = 5'd8;
    localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd9;
    localparam logic [KIND_W-1:0] KIND_COLON     = 5'd10;
    localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd11;
    localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_LBRACKET  = 5'd13;
    localparam logic [KIND_W-1:0] KIND_RBRACKET  = 5'd14;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_END       = 5'd16;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WS,
        MODE_NL,
        MODE_INT,
        MODE_FRAC,
        MODE_EMARK,
        MODE_EDIG,
        MODE_NSTR,
        MODE_ISTR
    } mode_t;

    typedef enum logic [3:0] {
        CLASS_UNK,
        CLASS_WS,
        CLASS_NL,
        CLASS_DIGIT,
        CLASS_CHAR,
        CLASS_DOT,
        CLASS_PLUS,
        CLASS_DASH,
        CLASS_MARK
    } class_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [LEN_BITS-1:0] length;
        logic                last;
    } token_t;

    // Kind of a single punctuation mark; unknown for anything that is not one.
    function automatic logic [KIND_W-1:0] mark_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        begin
            case (b)
                8'h2F, 8'h5C: k = KIND_SLASH;
                8'h2D:        k = KIND_DASH;
                8'h3D:        k = KIND_EQUAL;
                8'h3B:        k = KIND_SEMICOLON;
                8'h2C:        k = KIND_COMMA;
                8'h3A:        k = KIND_COLON;
                8'h28:        k = KIND_LPAREN;
                8'h29:        k = KIND_RPAREN;
                8'h5B:        k = KIND_LBRACKET;
                8'h5D:        k = KIND_RBRACKET;
                default:      k = KIND_UNKNOWN;
            endcase
            return k;
        end
    endfunction

    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        begin
            if (b inside {8'h09, 8'h20})
            begin
                c = CLASS_WS;
            end
            else if (b inside {8'h0A, 8'h0D})
            begin
                c = CLASS_NL;
            end
            else if (b inside {[8'h30:8'h39]})
            begin
                c = CLASS_DIGIT;
            end
            else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A],
                               8'h5F, 8'h3F, 8'h7C})
            begin
                c = CLASS_CHAR;
            end
            else if (b == 8'h2E)
            begin
                c = CLASS_DOT;
            end
            else if (b == 8'h2B)
            begin
                c = CLASS_PLUS;
            end
            else if (b == 8'h2D)
            begin
                c = CLASS_DASH;
            end
            else if (mark_kind(b) != KIND_UNKNOWN)
            begin
                c = CLASS_MARK;
            end
            else
            begin
                c = CLASS_UNK;
            end
            return c;
        end
    endfunction

endpackage

FILE: rtl/tts_scan.sv
// Token state of the scanner: the open token's mode and its length. One
// beat is consumed per step and yields zero, one or two tokens.
module tts_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    output logic [1:0]        tok_count,
    output tts_pkg::token_t   tok0,
    output tts_pkg::token_t   tok1
);

    tts_pkg::mode_t                mode_reg, mode_next;
    logic [tts_pkg::LEN_BITS-1:0]  len_reg, len_next;

    tts_pkg::class_t               cls;
    tts_pkg::mode_t                ext_mode;
    logic                          is_e;
    logic                          close_valid;
    logic [tts_pkg::KIND_W-1:0]    close_kind;
    logic                          second_valid;
    logic [tts_pkg::KIND_W-1:0]    second_kind;
    logic [tts_pkg::LEN_BITS-1:0]  second_len;

    assign cls  = tts_pkg::classify(text_byte);
    assign is_e = (text_byte == 8'h45) || (text_byte == 8'h65);

    // Mode after this byte if it extends the open token, else idle.
    always_comb
    begin
        ext_mode = tts_pkg::MODE_IDLE;
        case (mode_reg)
            tts_pkg::MODE_WS:
            begin
                if (cls == tts_pkg::CLASS_WS) ext_mode = tts_pkg::MODE_WS;
            end
            tts_pkg::MODE_NL:
            begin
                if (cls == tts_pkg::CLASS_NL) ext_mode = tts_pkg::MODE_NL;
            end
            tts_pkg::MODE_INT, tts_pkg::MODE_FRAC:
            begin
                if (cls == tts_pkg::CLASS_DIGIT)
                begin
                    ext_mode = mode_reg;
                end
                else if (cls == tts_pkg::CLASS_DOT && mode_reg == tts_pkg::MODE_INT)
                begin
                    ext_mode = tts_pkg::MODE_FRAC;
                end
                else if (cls == tts_pkg::CLASS_CHAR)
                begin
                    ext_mode = is_e ? tts_pkg::MODE_EMARK : tts_pkg::MODE_NSTR;
                end
            end
            tts_pkg::MODE_EMARK:
            begin
                if (cls inside {tts_pkg::CLASS_PLUS, tts_pkg::CLASS_DASH,
                                tts_pkg::CLASS_DIGIT})
                begin
                    ext_mode = tts_pkg::MODE_EDIG;
                end
                else if (cls == tts_pkg::CLASS_CHAR)
                begin
                    ext_mode = tts_pkg::MODE_NSTR;
                end
            end
            tts_pkg::MODE_EDIG:
            begin
                if (cls == tts_pkg::CLASS_DIGIT)
                begin
                    ext_mode = tts_pkg::MODE_EDIG;
                end
                else if (cls == tts_pkg::CLASS_CHAR)
                begin
                    ext_mode = tts_pkg::MODE_NSTR;
                end
            end
            tts_pkg::MODE_NSTR:
            begin
                if (cls inside {tts_pkg::CLASS_CHAR, tts_pkg::CLASS_DIGIT,
                                tts_pkg::CLASS_DOT})
                begin
                    ext_mode = tts_pkg::MODE_NSTR;
                end
            end
            tts_pkg::MODE_ISTR:
            begin
                if (cls inside {tts_pkg::CLASS_CHAR, tts_pkg::CLASS_DIGIT,
                                tts_pkg::CLASS_DASH, tts_pkg::CLASS_DOT})
                begin
                    ext_mode = tts_pkg::MODE_ISTR;
                end
            end
            default:
            begin
                ext_mode = tts_pkg::MODE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            tts_pkg::MODE_WS:                      close_kind = tts_pkg::KIND_SPACE;
            tts_pkg::MODE_NL:                      close_kind = tts_pkg::KIND_NEWLINE;
            tts_pkg::MODE_INT:                     close_kind = tts_pkg::KIND_INTEGER;
            tts_pkg::MODE_FRAC, tts_pkg::MODE_EDIG: close_kind = tts_pkg::KIND_FLOAT;
            default:                               close_kind = tts_pkg::KIND_STRING;
        endcase
    end

    // The open token closes on end of text or on a byte that cannot extend it;
    // the second token is a mark, an unknown byte or the end token.
    always_comb
    begin
        mode_next    = mode_reg;
        len_next     = len_reg;
        close_valid  = 1'b0;
        second_valid = 1'b0;
        second_kind  = tts_pkg::KIND_END;
        second_len   = '0;
        if (end_of_text)
        begin
            close_valid  = (mode_reg != tts_pkg::MODE_IDLE);
            second_valid = 1'b1;
            mode_next    = tts_pkg::MODE_IDLE;
            len_next     = '0;
        end
        else if (ext_mode != tts_pkg::MODE_IDLE)
        begin
            mode_next = ext_mode;
            if (len_reg != tts_pkg::LEN_MAX)
                len_next = len_reg + {{(tts_pkg::LEN_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            close_valid = (mode_reg != tts_pkg::MODE_IDLE);
            mode_next   = tts_pkg::MODE_IDLE;
            len_next    = '0;
            case (cls)
                tts_pkg::CLASS_WS:
                begin
                    mode_next = tts_pkg::MODE_WS;
                    len_next  = {{(tts_pkg::LEN_BITS-1){1'b0}}, 1'b1};
                end
                tts_pkg::CLASS_NL:
                begin
                    mode_next = tts_pkg::MODE_NL;
                    len_next  = {{(tts_pkg::LEN_BITS-1){1'b0}}, 1'b1};
                end
                tts_pkg::CLASS_DIGIT:
                begin
                    mode_next = tts_pkg::MODE_INT;
                    len_next  = {{(tts_pkg::LEN_BITS-1){1'b0}}, 1'b1};
                end
                tts_pkg::CLASS_CHAR:
                begin
                    mode_next = tts_pkg::MODE_ISTR;
                    len_next  = {{(tts_pkg::LEN_BITS-1){1'b0}}, 1'b1};
                end
                default:
                begin
                    // Marks, dashes and unknown bytes are single-byte tokens.
                    second_valid = 1'b1;
                    second_kind  = tts_pkg::mark_kind(text_byte);
                    second_len   = {{(tts_pkg::LEN_BITS-1){1'b0}}, 1'b1};
                end
            endcase
        end
    end

    always_comb
    begin
        tok_count   = {1'b0, close_valid} + {1'b0, second_valid};
        tok1.kind   = second_kind;
        tok1.length = second_len;
        tok1.last   = 1'b1;
        if (close_valid)
        begin
            tok0.kind   = close_kind;
            tok0.length = len_reg;
            tok0.last   = !second_valid;
        end
        else
        begin
            tok0 = tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tts_pkg::MODE_IDLE;
            len_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

endmodule

FILE: rtl/text_token_scanner.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// input    | in_valid, in_stall | text_byte[7:0], end_of_text
// result   | out_valid, out_stall | token_kind[4:0], token_length[15:0], last_of_run
//
// One input beat can be accepted every cycle while in_stall is low. A beat is
// held in the input register, then the scanner updates its mode and writes
// zero, one or two tokens into a four-entry result queue; the token at the
// queue head is shown on the result channel and taken when out_stall is low.
// The input stalls only while the queue lacks room for two tokens, so the
// sustained rate is one beat per cycle whenever the result side takes one
// token per cycle and beats give one token each.
// Reset idles the scanner with no token open and empties the queue.
module text_token_scanner (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    text_byte,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tts_pkg::KIND_W-1:0]    token_kind,
    output logic [tts_pkg::LEN_BITS-1:0]  token_length,
    output logic                          last_of_run
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input register.
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_eot_reg;

    // Result queue.
    tts_pkg::token_t     queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    logic                in_accept;
    logic                advance;
    logic                pop;
    logic [1:0]          tok_count;
    logic [1:0]          push_count;
    tts_pkg::token_t     tok0;
    tts_pkg::token_t     tok1;
    tts_pkg::token_t     head;

    // The held beat moves on only when the queue can take both of its tokens.
    assign advance   = s1_valid_reg && (count_reg <= QCNT_W'(QDEPTH - 2));
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    tts_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .text_byte   (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .tok_count   (tok_count),
        .tok0        (tok0),
        .tok1        (tok1)
    );

    assign push_count = advance ? tok_count : 2'd0;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= text_byte;
            s1_eot_reg  <= end_of_text;
        end
        if (push_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= tok0;
        end
        if (push_count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= tok1;
        end
    end

    assign head         = queue_reg[rd_ptr_reg];
    assign out_valid    = (count_reg != '0);
    assign token_kind   = head.kind;
    assign token_length = head.length;
    assign last_of_run  = head.last;

endmodule
